// File: rtl/grp_pkg.sv
// Shared types and constants for the guillotine rectangle packer.
// Used by grp_ctrl, grp_dp and guillotine_rect_packer_unit; no dependencies.
package grp_pkg;

	localparam int DEF_MAX_FREE_RECTS = 64;
	localparam int DEF_COORD_BITS     = 16;
	localparam int FLD_BITS           = 16;
	localparam int CFG_IDX_BITS       = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_RULE   = 2'd2;

	localparam logic [1:0] RULE_AREA  = 2'd0;
	localparam logic [1:0] RULE_SHORT = 2'd1;
	localparam logic [1:0] RULE_LONG  = 2'd2;

	localparam int            RESET_BIN  = 1024;
	localparam logic [1:0]    RESET_RULE = RULE_AREA;
	localparam logic          ACT_CLEAR  = 1'b1;

	// write data select for the free-list memory
	localparam logic [2:0] WSEL_MOVE   = 3'd0;
	localparam logic [2:0] WSEL_PIECE0 = 3'd1;
	localparam logic [2:0] WSEL_PIECE1 = 3'd2;
	localparam logic [2:0] WSEL_MERGE  = 3'd3;
	localparam logic [2:0] WSEL_INIT   = 3'd4;
	localparam logic [2:0] WSEL_CLEAR  = 3'd5;

	typedef struct packed {
		logic       cap_in;
		logic       scan_start;
		logic       eval;
		logic       take_exact;
		logic       cmp;
		logic       split_mul;
		logic       split_piece;
		logic       ovf_set;
		logic       a_load;
		logic       a_upd;
		logic       out_load;
		logic       out_placed;
		logic       rd_en;
		logic       wr_en;
		logic [2:0] wr_sel;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic zero_blk;
		logic bin_ok;
		logic exact;
		logic better;
		logic found;
		logic piece0_ok;
		logic piece1_ok;
		logic joined;
		logic out_busy;
	} stat_t;

endpackage

// File: rtl/grp_dp.sv
// Datapath of the packer: config registers, free-list memory, fit scoring,
// split and merge arithmetic, output register. Depends on grp_pkg.
module grp_dp #(
	parameter int MAX_FREE_RECTS = grp_pkg::DEF_MAX_FREE_RECTS,
	parameter int COORD_BITS     = grp_pkg::DEF_COORD_BITS,
	parameter int AW             = $clog2(MAX_FREE_RECTS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [grp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [grp_pkg::FLD_BITS-1:0]      cfg_data,
	input  logic                              action,
	input  logic [grp_pkg::FLD_BITS-1:0]      block_width,
	input  logic [grp_pkg::FLD_BITS-1:0]      block_height,
	input  grp_pkg::cmd_t                     cmd,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [AW-1:0]                     wr_addr,
	input  logic                              out_stall,
	output grp_pkg::stat_t                    st,
	output logic                              out_valid,
	output logic                              placed,
	output logic [grp_pkg::FLD_BITS-1:0]      pos_x,
	output logic [grp_pkg::FLD_BITS-1:0]      pos_y,
	output logic [grp_pkg::FLD_BITS-1:0]      used_width,
	output logic [grp_pkg::FLD_BITS-1:0]      used_height,
	output logic                              turned,
	output logic                              list_overflow
);

	localparam int CB     = COORD_BITS;
	localparam int SW     = 2 * CB;
	localparam int FB     = grp_pkg::FLD_BITS;
	localparam int CMAX_I = (1 << CB) - 1;
	localparam logic [CB-1:0] CMAX   = CB'(CMAX_I);
	localparam logic [CB-1:0] INIT_B = (grp_pkg::RESET_BIN > CMAX_I) ? CMAX
		: CB'(grp_pkg::RESET_BIN);

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] w;
		logic [CB-1:0] h;
	} rect_t;

	rect_t mem [MAX_FREE_RECTS];
	rect_t rd_q;
	rect_t ch_q;
	rect_t a_q;
	rect_t piece0_q;
	rect_t piece1_q;
	rect_t wdata;
	rect_t a_nx;

	logic [FB-1:0] bin_w_q;
	logic [FB-1:0] bin_h_q;
	logic [1:0]    rule_q;
	logic          act_q;
	logic [FB-1:0] bw_q;
	logic [FB-1:0] bh_q;

	logic [CB-1:0] bin_ws;
	logic [CB-1:0] bin_hs;

	logic          ex_up, ex_tn, ft_up, ft_tn, ev_turn;
	logic [CB-1:0] ow, oh;
	logic          fit_s1, turn_s1;
	logic [CB-1:0] ow_s1, oh_s1, dw_s1, dh_s1;
	logic [SW-1:0] p0_s1, p1_s1;
	logic [CB-1:0] mop_a, mop_b, mop_c, mop_d;
	logic [SW-1:0] score;
	logic [SW-1:0] best_q;
	logic          found_q;
	logic          better;
	logic [CB-1:0] pw_q, ph_q;
	logic          turn_q;
	logic          ovf_q;
	logic [CB-1:0] rw, rh;
	logic          horiz;
	logic          p0ok_q, p1ok_q;
	logic          joined;
	logic          out_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_w_q <= FB'(grp_pkg::RESET_BIN);
			bin_h_q <= FB'(grp_pkg::RESET_BIN);
			rule_q  <= grp_pkg::RESET_RULE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grp_pkg::CFG_BIN_WIDTH:  bin_w_q <= cfg_data;
				grp_pkg::CFG_BIN_HEIGHT: bin_h_q <= cfg_data;
				grp_pkg::CFG_FIT_RULE:   rule_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign bin_ws = (bin_w_q > FB'(CMAX)) ? CMAX : bin_w_q[CB-1:0];
	assign bin_hs = (bin_h_q > FB'(CMAX)) ? CMAX : bin_h_q[CB-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			act_q <= action;
			bw_q  <= block_width;
			bh_q  <= block_height;
		end
	end

	// orientation and fit of the entry just read
	always_comb begin
		ex_up   = (bw_q == FB'(rd_q.w)) && (bh_q == FB'(rd_q.h));
		ex_tn   = (bh_q == FB'(rd_q.w)) && (bw_q == FB'(rd_q.h));
		ft_up   = (bw_q <= FB'(rd_q.w)) && (bh_q <= FB'(rd_q.h));
		ft_tn   = (bh_q <= FB'(rd_q.w)) && (bw_q <= FB'(rd_q.h));
		ev_turn = !ex_up && (ex_tn || !ft_up);
		ow      = ev_turn ? bh_q[CB-1:0] : bw_q[CB-1:0];
		oh      = ev_turn ? bw_q[CB-1:0] : bh_q[CB-1:0];
	end

	assign rw = ch_q.w - pw_q;
	assign rh = ch_q.h - ph_q;

	// two multipliers shared by scoring and the split decision
	assign mop_a = cmd.split_mul ? pw_q : rd_q.w;
	assign mop_b = cmd.split_mul ? rh   : rd_q.h;
	assign mop_c = cmd.split_mul ? rw   : ow;
	assign mop_d = cmd.split_mul ? ph_q : oh;

	always_ff @(posedge clk) begin
		if (cmd.eval || cmd.split_mul) begin
			p0_s1 <= SW'(mop_a) * SW'(mop_b);
			p1_s1 <= SW'(mop_c) * SW'(mop_d);
		end
		if (cmd.eval) begin
			turn_s1 <= ev_turn;
			ow_s1   <= ow;
			oh_s1   <= oh;
			dw_s1   <= rd_q.w - ow;
			dh_s1   <= rd_q.h - oh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_s1 <= 1'b0;
		end else if (cmd.eval) begin
			fit_s1 <= ft_up || ft_tn;
		end
	end

	always_comb begin
		unique case (rule_q)
			grp_pkg::RULE_AREA:  score = p0_s1 - p1_s1;
			grp_pkg::RULE_SHORT: score = SW'((dw_s1 < dh_s1) ? dw_s1 : dh_s1);
			grp_pkg::RULE_LONG:  score = SW'((dw_s1 > dh_s1) ? dw_s1 : dh_s1);
			default:             score = '0;
		endcase
	end

	assign better = fit_s1 && (!found_q || (score < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				found_q <= 1'b0;
				ovf_q   <= 1'b0;
			end else if (cmd.take_exact || (cmd.cmp && better)) begin
				found_q <= 1'b1;
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// chosen entry
	always_ff @(posedge clk) begin
		if (cmd.take_exact) begin
			ch_q   <= rd_q;
			pw_q   <= ow;
			ph_q   <= oh;
			turn_q <= ev_turn;
		end else if (cmd.cmp && better) begin
			ch_q   <= rd_q;
			pw_q   <= ow_s1;
			ph_q   <= oh_s1;
			turn_q <= turn_s1;
			best_q <= score;
		end
	end

	// min-area split into bottom and right pieces
	assign horiz = p0_s1 > p1_s1;

	always_ff @(posedge clk) begin
		if (cmd.split_piece) begin
			piece0_q.x <= ch_q.x;
			piece0_q.y <= ch_q.y + ph_q;
			piece0_q.w <= horiz ? ch_q.w : pw_q;
			piece0_q.h <= rh;
			piece1_q.x <= ch_q.x + pw_q;
			piece1_q.y <= ch_q.y;
			piece1_q.w <= rw;
			piece1_q.h <= horiz ? ph_q : ch_q.h;
			p0ok_q     <= (rh != '0) && ((horiz ? ch_q.w : pw_q) != '0);
			p1ok_q     <= (rw != '0) && ((horiz ? ph_q : ch_q.h) != '0);
		end
	end

	// join of the held entry with the entry just read
	always_comb begin
		a_nx   = a_q;
		joined = 1'b0;
		if ((a_q.w == rd_q.w) && (a_q.x == rd_q.x)) begin
			if ({1'b0, a_q.y} == ({1'b0, rd_q.y} + {1'b0, rd_q.h})) begin
				a_nx.y = rd_q.y;
				a_nx.h = a_q.h + rd_q.h;
				joined = 1'b1;
			end else if (({1'b0, a_q.y} + {1'b0, a_q.h}) == {1'b0, rd_q.y}) begin
				a_nx.h = a_q.h + rd_q.h;
				joined = 1'b1;
			end
		end else if ((a_q.h == rd_q.h) && (a_q.y == rd_q.y)) begin
			if ({1'b0, a_q.x} == ({1'b0, rd_q.x} + {1'b0, rd_q.w})) begin
				a_nx.x = rd_q.x;
				a_nx.w = a_q.w + rd_q.w;
				joined = 1'b1;
			end else if (({1'b0, a_q.x} + {1'b0, a_q.w}) == {1'b0, rd_q.x}) begin
				a_nx.w = a_q.w + rd_q.w;
				joined = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.a_load) begin
			a_q <= rd_q;
		end else if (cmd.a_upd) begin
			a_q <= a_nx;
		end
	end

	always_comb begin
		unique case (cmd.wr_sel)
			grp_pkg::WSEL_MOVE:   wdata = rd_q;
			grp_pkg::WSEL_PIECE0: wdata = piece0_q;
			grp_pkg::WSEL_PIECE1: wdata = piece1_q;
			grp_pkg::WSEL_MERGE:  wdata = a_q;
			grp_pkg::WSEL_INIT:   wdata = '{x: '0, y: '0, w: INIT_B, h: INIT_B};
			grp_pkg::WSEL_CLEAR:  wdata = '{x: '0, y: '0, w: bin_ws, h: bin_hs};
			default:              wdata = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			placed        <= cmd.out_placed;
			pos_x         <= cmd.out_placed ? FB'(ch_q.x) : '0;
			pos_y         <= cmd.out_placed ? FB'(ch_q.y) : '0;
			used_width    <= cmd.out_placed ? FB'(pw_q) : '0;
			used_height   <= cmd.out_placed ? FB'(ph_q) : '0;
			turned        <= cmd.out_placed && turn_q;
			list_overflow <= cmd.out_placed && ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st.action    = act_q;
		st.zero_blk  = (bw_q == '0) || (bh_q == '0);
		st.bin_ok    = (bin_ws != '0) && (bin_hs != '0);
		st.exact     = ex_up || ex_tn;
		st.better    = better;
		st.found     = found_q;
		st.piece0_ok = p0ok_q;
		st.piece1_ok = p1ok_q;
		st.joined    = joined;
		st.out_busy  = out_valid_q && out_stall;
	end

endmodule

// File: rtl/grp_ctrl.sv
// Controller of the packer: sequences scan, split, removal, append and merge
// over the free-list memory. Depends on grp_pkg.
module grp_ctrl #(
	parameter int MAX_FREE_RECTS = grp_pkg::DEF_MAX_FREE_RECTS,
	parameter int AW             = $clog2(MAX_FREE_RECTS),
	parameter int CW             = $clog2(MAX_FREE_RECTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  grp_pkg::stat_t st,
	output grp_pkg::cmd_t  cmd,
	output logic [AW-1:0]  rd_addr,
	output logic [AW-1:0]  wr_addr
);

	localparam logic [4:0] S_INIT     = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_DECODE   = 5'd2;
	localparam logic [4:0] S_SCAN_RD  = 5'd3;
	localparam logic [4:0] S_SCAN_EV  = 5'd4;
	localparam logic [4:0] S_SCAN_CMP = 5'd5;
	localparam logic [4:0] S_SPLIT    = 5'd6;
	localparam logic [4:0] S_SPLIT2   = 5'd7;
	localparam logic [4:0] S_DROP_RD  = 5'd8;
	localparam logic [4:0] S_DROP_WR  = 5'd9;
	localparam logic [4:0] S_APP0     = 5'd10;
	localparam logic [4:0] S_APP1     = 5'd11;
	localparam logic [4:0] S_M_I      = 5'd12;
	localparam logic [4:0] S_M_A      = 5'd13;
	localparam logic [4:0] S_M_JRD    = 5'd14;
	localparam logic [4:0] S_M_JEV    = 5'd15;
	localparam logic [4:0] S_M_JCHK   = 5'd16;
	localparam logic [4:0] S_DONE     = 5'd17;

	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_RECTS);

	logic [4:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] sel_q, sel_d;
	logic          ret_merge_q, ret_merge_d;
	logic          placed_q, placed_d;
	logic [CW-1:0] k_nx;

	assign k_nx     = k_q + ONE;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		sel_d       = sel_q;
		ret_merge_d = ret_merge_q;
		placed_d    = placed_q;
		cmd         = '0;
		rd_addr     = i_q[AW-1:0];
		wr_addr     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = grp_pkg::WSEL_INIT;
				count_d    = ONE;
				state_d    = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				placed_d = 1'b0;
				if (st.action == grp_pkg::ACT_CLEAR) begin
					if (st.bin_ok) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = grp_pkg::WSEL_CLEAR;
						count_d    = ONE;
					end else begin
						count_d = '0;
					end
					state_d = S_DONE;
				end else if (st.zero_blk || (count_q == '0)) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					i_d            = '0;
					state_d        = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.eval = 1'b1;
				if (st.exact) begin
					cmd.take_exact = 1'b1;
					sel_d          = i_q;
					state_d        = S_SPLIT;
				end else begin
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				cmd.cmp = 1'b1;
				if (st.better) begin
					sel_d = i_q;
				end
				i_d = i_q + ONE;
				if ((i_q + ONE) == count_q) begin
					state_d = (st.found || st.better) ? S_SPLIT : S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SPLIT: begin
				cmd.split_mul = 1'b1;
				state_d       = S_SPLIT2;
			end
			S_SPLIT2: begin
				// remove the chosen entry, then append the pieces
				cmd.split_piece = 1'b1;
				k_d             = sel_q;
				ret_merge_d     = 1'b0;
				if ((sel_q + ONE) < count_q) begin
					state_d = S_DROP_RD;
				end else begin
					count_d = count_q - ONE;
					state_d = S_APP0;
				end
			end
			S_DROP_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = k_nx[AW-1:0];
				state_d   = S_DROP_WR;
			end
			S_DROP_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = grp_pkg::WSEL_MOVE;
				wr_addr    = k_q[AW-1:0];
				k_d        = k_nx;
				if ((k_nx + ONE) < count_q) begin
					state_d = S_DROP_RD;
				end else begin
					count_d = count_q - ONE;
					state_d = ret_merge_q ? S_M_JCHK : S_APP0;
				end
			end
			S_APP0: begin
				if (st.piece0_ok) begin
					if (count_q >= MAXC) begin
						cmd.ovf_set = 1'b1;
					end else begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = grp_pkg::WSEL_PIECE0;
						wr_addr    = count_q[AW-1:0];
						count_d    = count_q + ONE;
					end
				end
				state_d = S_APP1;
			end
			S_APP1: begin
				if (st.piece1_ok) begin
					if (count_q >= MAXC) begin
						cmd.ovf_set = 1'b1;
					end else begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = grp_pkg::WSEL_PIECE1;
						wr_addr    = count_q[AW-1:0];
						count_d    = count_q + ONE;
					end
				end
				i_d     = '0;
				state_d = S_M_I;
			end
			S_M_I: begin
				if ((i_q + ONE) < count_q) begin
					cmd.rd_en = 1'b1;
					j_d       = i_q + ONE;
					state_d   = S_M_A;
				end else begin
					placed_d = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_M_A: begin
				cmd.a_load = 1'b1;
				state_d    = S_M_JRD;
			end
			S_M_JRD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = j_q[AW-1:0];
				state_d   = S_M_JEV;
			end
			S_M_JEV: begin
				if (st.joined) begin
					// fold into the held entry and remove entry j
					cmd.a_upd   = 1'b1;
					k_d         = j_q;
					ret_merge_d = 1'b1;
					if ((j_q + ONE) < count_q) begin
						state_d = S_DROP_RD;
					end else begin
						count_d = count_q - ONE;
						state_d = S_M_JCHK;
					end
				end else begin
					j_d     = j_q + ONE;
					state_d = S_M_JCHK;
				end
			end
			S_M_JCHK: begin
				if (j_q < count_q) begin
					state_d = S_M_JRD;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = grp_pkg::WSEL_MERGE;
					wr_addr    = i_q[AW-1:0];
					i_d        = i_q + ONE;
					state_d    = S_M_I;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.out_load   = 1'b1;
					cmd.out_placed = placed_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= ONE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			sel_q       <= '0;
			ret_merge_q <= 1'b0;
			placed_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			sel_q       <= sel_d;
			ret_merge_q <= ret_merge_d;
			placed_q    <= placed_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC)
		else $error("free count beyond list depth");
	a_wr_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (CW'(wr_addr) <= count_q))
		else $error("free-list write beyond the valid entries");
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted beat not decoded");
	a_sel_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (sel_q < count_q))
		else $error("chosen entry outside the list");
`endif

endmodule

// File: rtl/guillotine_rect_packer_unit.sv
// Guillotine rectangle packer: top level joining grp_ctrl and grp_dp (uses grp_pkg).
// From accepted beat to result valid: a clear or zero-size item goes straight to the result;
// else the n free entries are scanned (an exact fit ends the scan early); on a fit the chosen
// entry is split and removed (later entries move down), the pieces appended, pairs merged.
// One item in flight; next beat taken the cycle after the result loads.
// Reset: asynchronous; after release the full-bin entry is written, stall high.
module guillotine_rect_packer_unit #(
	parameter int MAX_FREE_RECTS = grp_pkg::DEF_MAX_FREE_RECTS,
	parameter int COORD_BITS     = grp_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [grp_pkg::FLD_BITS-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [grp_pkg::FLD_BITS-1:0]     block_width,
	input  logic [grp_pkg::FLD_BITS-1:0]     block_height,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             placed,
	output logic [grp_pkg::FLD_BITS-1:0]     pos_x,
	output logic [grp_pkg::FLD_BITS-1:0]     pos_y,
	output logic [grp_pkg::FLD_BITS-1:0]     used_width,
	output logic [grp_pkg::FLD_BITS-1:0]     used_height,
	output logic                             turned,
	output logic                             list_overflow
);

	localparam int AW = $clog2(MAX_FREE_RECTS);
	localparam int CW = $clog2(MAX_FREE_RECTS + 1);

	grp_pkg::cmd_t  cmd;
	grp_pkg::stat_t st;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;

	grp_ctrl #(
		.MAX_FREE_RECTS (MAX_FREE_RECTS),
		.AW             (AW),
		.CW             (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	grp_dp #(
		.MAX_FREE_RECTS (MAX_FREE_RECTS),
		.COORD_BITS     (COORD_BITS),
		.AW             (AW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.block_width   (block_width),
		.block_height  (block_height),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.wr_addr       (wr_addr),
		.out_stall     (out_stall),
		.st            (st),
		.out_valid     (out_valid),
		.placed        (placed),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.used_width    (used_width),
		.used_height   (used_height),
		.turned        (turned),
		.list_overflow (list_overflow)
	);

endmodule
